[rtl/core/dhd_pkg.sv]
`timescale 1ns / 1ps
package dhd_pkg;

    localparam int MAX_CLASSES_DEF     = 80;
    localparam int COORD_FRAC_BITS_DEF = 4;

    localparam int COORD_W     = 16;
    localparam int SCORE_W     = 16;
    localparam int CLASS_W     = 8;
    localparam int PAD_W       = 12;
    localparam int ORIG_W      = 12;
    localparam int INV_SCALE_W = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 3;

    localparam int JOB_FIFO_DEPTH = 2;

    localparam logic [SCORE_W-1:0]     CONF_THRESHOLD_RST = 16'd16384;
    localparam logic [PAD_W-1:0]       PAD_X_RST          = 12'd0;
    localparam logic [PAD_W-1:0]       PAD_Y_RST          = 12'd0;
    localparam logic [INV_SCALE_W-1:0] INV_SCALE_RST      = 24'd65536;
    localparam logic [ORIG_W-1:0]      ORIG_WIDTH_RST     = 12'd640;
    localparam logic [ORIG_W-1:0]      ORIG_HEIGHT_RST    = 12'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONF_THRESHOLD = 3'd0,
        REG_PAD_X          = 3'd1,
        REG_PAD_Y          = 3'd2,
        REG_INV_SCALE      = 3'd3,
        REG_ORIG_WIDTH     = 3'd4,
        REG_ORIG_HEIGHT    = 3'd5
    } cfg_index_t;

    typedef enum logic {
        REQ_BOX   = 1'b0,
        REQ_SCORE = 1'b1
    } req_type_t;

    typedef struct packed {
        logic                 req_type;
        logic [COORD_W-1:0]   center_x;
        logic [COORD_W-1:0]   center_y;
        logic [COORD_W-1:0]   box_width;
        logic [COORD_W-1:0]   box_height;
        logic [SCORE_W-1:0]   class_score;
        logic                 last_score;
    } req_word_t;

    typedef struct packed {
        logic [COORD_W-1:0]   x_left;
        logic [COORD_W-1:0]   y_top;
        logic [COORD_W-1:0]   x_right;
        logic [COORD_W-1:0]   y_bottom;
        logic [SCORE_W-1:0]   confidence;
        logic [CLASS_W-1:0]   class_id;
    } det_word_t;

    typedef struct packed {
        logic [SCORE_W-1:0]     conf_threshold;
        logic [PAD_W-1:0]       pad_x;
        logic [PAD_W-1:0]       pad_y;
        logic [INV_SCALE_W-1:0] inv_scale;
        logic [ORIG_W-1:0]      orig_width;
        logic [ORIG_W-1:0]      orig_height;
    } cfg_t;

    // one detection waiting for corner math
    typedef struct packed {
        logic [COORD_W-1:0]   cx;
        logic [COORD_W-1:0]   cy;
        logic [COORD_W-1:0]   w;
        logic [COORD_W-1:0]   h;
        logic [SCORE_W-1:0]   score;
        logic [CLASS_W-1:0]   class_id;
    } job_t;

endpackage

[rtl/core/dhd_front.sv]
`timescale 1ns / 1ps
module dhd_front
    import dhd_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  req_word_t           word,
    input  logic [SCORE_W-1:0]  conf_threshold,
    output logic                push,
    output job_t                job
);

    logic [COORD_W-1:0] cx_reg, cy_reg, w_reg, h_reg;
    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [CLASS_W-1:0] best_class_reg, best_class_next;
    logic [CLASS_W-1:0] class_cnt_reg, class_cnt_next;
    logic               cnt_ok;
    logic               take;

    always_comb
    begin
        cnt_ok = class_cnt_reg < CLASS_W'(MAX_CLASSES);
        // first score always wins, later ones only when strictly greater
        take = cnt_ok && ((class_cnt_reg == '0) || (word.class_score > best_score_reg));
        best_score_next = take ? word.class_score : best_score_reg;
        best_class_next = take ? class_cnt_reg : best_class_reg;
        class_cnt_next  = cnt_ok ? class_cnt_reg + 1'b1 : class_cnt_reg;

        push = accept && (word.req_type == REQ_SCORE) && word.last_score
               && (best_score_next >= conf_threshold);

        job.cx       = cx_reg;
        job.cy       = cy_reg;
        job.w        = w_reg;
        job.h        = h_reg;
        job.score    = best_score_next;
        job.class_id = best_class_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg         <= '0;
            cy_reg         <= '0;
            w_reg          <= '0;
            h_reg          <= '0;
            best_score_reg <= '0;
            best_class_reg <= '0;
            class_cnt_reg  <= '0;
        end
        else if (accept)
        begin
            if (word.req_type == REQ_BOX)
            begin
                cx_reg         <= word.center_x;
                cy_reg         <= word.center_y;
                w_reg          <= word.box_width;
                h_reg          <= word.box_height;
                best_score_reg <= '0;
                best_class_reg <= '0;
                class_cnt_reg  <= '0;
            end
            else if (word.last_score)
            begin
                best_score_reg <= '0;
                best_class_reg <= '0;
                class_cnt_reg  <= '0;
            end
            else
            begin
                best_score_reg <= best_score_next;
                best_class_reg <= best_class_next;
                class_cnt_reg  <= class_cnt_next;
            end
        end
    end

endmodule

[rtl/core/dhd_fifo.sv]
`timescale 1ns / 1ps
module dhd_fifo
    import dhd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_data,
    input  logic    pop,
    output job_t    pop_data,
    output logic    empty,
    output logic    full
);

    localparam int PTR_W = (JOB_FIFO_DEPTH > 1) ? $clog2(JOB_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(JOB_FIFO_DEPTH + 1);

    job_t               job_mem [JOB_FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        empty    = (count_reg == '0);
        full     = (count_reg == CNT_W'(JOB_FIFO_DEPTH));
        pop_data = job_mem[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            job_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/dhd_back.sv]
`timescale 1ns / 1ps
module dhd_back
    import dhd_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    input  cfg_t        cfg,
    output logic        pop,
    output logic        det_valid,
    input  logic        det_stall,
    output det_word_t   det_word
);

    localparam int F  = COORD_FRAC_BITS;
    // signed corner value: 2c +/- size - pad << (F+1), with headroom
    localparam int VW = ((18 > PAD_W + F + 1) ? 18 : PAD_W + F + 1) + 2;
    localparam int MW = VW - 1;
    localparam int PW = MW + INV_SCALE_W;
    localparam int RW = PW - 16;

    function automatic logic [MW-1:0] corner_mag(
        input logic [COORD_W-1:0] c,
        input logic [COORD_W-1:0] size,
        input logic [PAD_W-1:0]   pad,
        input logic               plus
    );
        logic [VW-1:0] v;
        v = (VW'(c) << 1) - (VW'(pad) << (F + 1));
        v = plus ? v + VW'(size) : v - VW'(size);
        corner_mag = (v[VW-1] || (v == '0)) ? '0 : v[MW-1:0];
    endfunction

    // round half up to F fraction bits, then clamp to image and to 16 bits
    function automatic logic [COORD_W-1:0] finish(
        input logic [PW-1:0]     prod,
        input logic [ORIG_W-1:0] orig
    );
        logic [PW:0]   sum;
        logic [RW-1:0] r;
        logic [RW-1:0] lim;
        sum = {1'b0, prod} + (PW + 1)'(17'h10000);
        r   = sum[PW:17];
        lim = RW'(orig) << F;
        if (r > lim)
        begin
            r = lim;
        end
        finish = (r > RW'(16'hFFFF)) ? 16'hFFFF : r[COORD_W-1:0];
    endfunction

    logic              en1, en2, en3;

    logic [MW-1:0]      mag_reg [4];
    logic [MW-1:0]      mag_next [4];
    logic [SCORE_W-1:0] s1_score_reg;
    logic [CLASS_W-1:0] s1_class_reg;
    logic               s1_valid_reg;

    logic [PW-1:0]      prod_reg [4];
    logic [PW-1:0]      prod_next [4];
    logic [SCORE_W-1:0] s2_score_reg;
    logic [CLASS_W-1:0] s2_class_reg;
    logic               s2_valid_reg;

    det_word_t          det_word_reg, det_word_next;
    logic               det_valid_reg;

    always_comb
    begin
        en3 = !det_valid_reg || !det_stall;
        en2 = !s2_valid_reg || en3;
        en1 = !s1_valid_reg || en2;
        pop = job_valid && en1;

        mag_next[0] = corner_mag(job.cx, job.w, cfg.pad_x, 1'b0);
        mag_next[1] = corner_mag(job.cy, job.h, cfg.pad_y, 1'b0);
        mag_next[2] = corner_mag(job.cx, job.w, cfg.pad_x, 1'b1);
        mag_next[3] = corner_mag(job.cy, job.h, cfg.pad_y, 1'b1);

        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = PW'(mag_reg[i]) * PW'(cfg.inv_scale);
        end

        det_word_next.x_left     = finish(prod_reg[0], cfg.orig_width);
        det_word_next.y_top      = finish(prod_reg[1], cfg.orig_height);
        det_word_next.x_right    = finish(prod_reg[2], cfg.orig_width);
        det_word_next.y_bottom   = finish(prod_reg[3], cfg.orig_height);
        det_word_next.confidence = s2_score_reg;
        det_word_next.class_id   = s2_class_reg;

        det_valid = det_valid_reg;
        det_word  = det_word_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en1 && pop)
        begin
            mag_reg      <= mag_next;
            s1_score_reg <= job.score;
            s1_class_reg <= job.class_id;
        end
        if (en2 && s1_valid_reg)
        begin
            prod_reg     <= prod_next;
            s2_score_reg <= s1_score_reg;
            s2_class_reg <= s1_class_reg;
        end
        if (en3 && s2_valid_reg)
        begin
            det_word_reg <= det_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            det_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= pop;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                det_valid_reg <= s2_valid_reg;
            end
        end
    end

endmodule

[rtl/core/detection_head_decode_top.sv]
`timescale 1ns / 1ps
// Takes one request word per cycle; only a full detection queue stalls the input.
// A detection leaves, once its last score word is taken, through the queue, corner
// offsets, multiply, and round and clamp; box and non-emitting score words give no output.
// Throughput: 1 word/cycle, bounded by the single argmax compare and one multiplier per corner.
// Reset: config returns to defaults, box store and argmax clear, queue and pipeline empty.
module detection_head_decode_top
    import dhd_pkg::*;
#(
    parameter int MAX_CLASSES     = MAX_CLASSES_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  req_word_t               req_word,
    output logic                    det_valid,
    input  logic                    det_stall,
    output det_word_t               det_word,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    cfg_t   cfg_reg;
    logic   req_accept;
    logic   push;
    job_t   push_job;
    logic   pop;
    job_t   pop_job;
    logic   fifo_empty;
    logic   fifo_full;

    assign req_stall  = fifo_full;
    assign req_accept = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conf_threshold <= CONF_THRESHOLD_RST;
            cfg_reg.pad_x          <= PAD_X_RST;
            cfg_reg.pad_y          <= PAD_Y_RST;
            cfg_reg.inv_scale      <= INV_SCALE_RST;
            cfg_reg.orig_width     <= ORIG_WIDTH_RST;
            cfg_reg.orig_height    <= ORIG_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_CONF_THRESHOLD: cfg_reg.conf_threshold <= cfg_data[SCORE_W-1:0];
                REG_PAD_X:          cfg_reg.pad_x          <= cfg_data[PAD_W-1:0];
                REG_PAD_Y:          cfg_reg.pad_y          <= cfg_data[PAD_W-1:0];
                REG_INV_SCALE:      cfg_reg.inv_scale      <= cfg_data[INV_SCALE_W-1:0];
                REG_ORIG_WIDTH:     cfg_reg.orig_width     <= cfg_data[ORIG_W-1:0];
                REG_ORIG_HEIGHT:    cfg_reg.orig_height    <= cfg_data[ORIG_W-1:0];
                default: ;
            endcase
        end
    end

    dhd_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (req_accept),
        .word           (req_word),
        .conf_threshold (cfg_reg.conf_threshold),
        .push           (push),
        .job            (push_job)
    );

    dhd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_job),
        .pop        (pop),
        .pop_data   (pop_job),
        .empty      (fifo_empty),
        .full       (fifo_full)
    );

    dhd_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (!fifo_empty),
        .job        (pop_job),
        .cfg        (cfg_reg),
        .pop        (pop),
        .det_valid  (det_valid),
        .det_stall  (det_stall),
        .det_word   (det_word)
    );

    // corners stay ordered through rounding and clamping
    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        det_valid |-> (det_word.x_left <= det_word.x_right)
                      && (det_word.y_top <= det_word.y_bottom))
        else $error("detection corners out of order");

    a_conf_pass: assert property (@(posedge clk) disable iff (!rst_n)
        det_valid |-> (det_word.confidence >= cfg_reg.conf_threshold))
        else $error("detection below threshold");

    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        det_valid |-> (det_word.class_id < CLASS_W'(MAX_CLASSES)))
        else $error("class id beyond class count");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_full)
        else $error("push into full detection queue");

endmodule
